### src/sat_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sat_pkg
// shared types and codes of the shifting array table
// ----------------------------------------------------------------------------
package sat_pkg;

	localparam int OP_W   = 3;
	localparam int POS_W  = 9;
	localparam int WORD_W = 32;
	localparam int STAT_W = 2;

	// request kinds
	localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
	localparam logic [OP_W-1:0] OP_POP    = 3'd1;
	localparam logic [OP_W-1:0] OP_INSERT = 3'd2;
	localparam logic [OP_W-1:0] OP_DELETE = 3'd3;
	localparam logic [OP_W-1:0] OP_READ   = 3'd4;
	localparam logic [OP_W-1:0] OP_REMOVE = 3'd5;

	// result status
	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]          op;
		logic [POS_W-1:0]         position;
		logic signed [WORD_W-1:0] data;
	} req_t;

	typedef struct packed {
		logic [STAT_W-1:0]        status;
		logic signed [WORD_W-1:0] read_value;
		logic [POS_W-1:0]         count;
	} rsp_t;

endpackage

### src/sat_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sat_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module sat_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(DEPTH)-1:0]   waddr,
	input  logic [WIDTH-1:0]           wdata,
	input  logic                       re,
	input  logic [$clog2(DEPTH)-1:0]   raddr,
	output logic [WIDTH-1:0]           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### src/shifting_array_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shifting_array_table
// ordered table of signed words with push, pop, insert, delete, read, remove
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Every item gives
// exactly one result, shown on rsp for one cycle with done high; the receiver
// cannot stall, so it must take the result in that cycle. The words live in
// one simple dual-port ram (one write, one registered read per cycle); the
// walks step through that ram one entry per cycle. Push, an append at the end
// and every rejected item answer in the cycle after acceptance and busy never
// rises. Pop and read fetch one word in S_SCAN; insert walks down from the top
// entry, moving each up one, then drops the new word in during S_INSFIN; delete
// walks up from the deleted entry, moving each down one; remove compacts the
// whole table. The next item may be accepted in the cycle in which done is high.
// No clearing pass is needed after reset: only entries below the count are ever read.
// ----------------------------------------------------------------------------
module shifting_array_table #(
	parameter int DEPTH = 256
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  sat_pkg::req_t req,
	output logic          busy,
	output logic          done,
	output sat_pkg::rsp_t rsp
);

	import sat_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = (CW > POS_W) ? CW : POS_W;

	// sequencer states
	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SCAN   = 2'd1;
	localparam logic [1:0] S_INSFIN = 2'd2;

	// control state
	logic [1:0]    state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic          done_q, done_d;

	// item and walk context
	logic [OP_W-1:0]   op_q, op_d;
	logic [AW-1:0]     pos_q, pos_d;
	logic [WORD_W-1:0] data_q, data_d;
	logic [AW-1:0]     end_q, end_d;     // address of the final read
	logic              up_q, up_d;       // walk direction
	logic [CW-1:0]     kept_q, kept_d;   // survivors so far in a remove
	logic [WORD_W-1:0] val_q, val_d;     // word taken out by a delete
	rsp_t              rsp_q, rsp_d;

	// read in flight: its address and whether it is the last of the walk
	logic [AW-1:0] rda_s1, rda_d;
	logic          last_s1, last_d;

	// ram port
	logic              ram_we, ram_re;
	logic [AW-1:0]     ram_wa, ram_ra;
	logic [WORD_W-1:0] ram_wd, rd_data;

	// decode helpers
	logic              acc;
	logic [XW-1:0]     pos_x, cnt_x;
	logic              full, empty;
	logic [AW-1:0]     last_a, req_a, nxt_a;
	logic [CW-1:0]     kept_n;

	assign busy = (state_q != S_IDLE);
	assign acc  = start && !busy;

	assign pos_x  = XW'(req.position);
	assign cnt_x  = XW'(cnt_q);
	assign full   = (cnt_q == CW'(DEPTH));
	assign empty  = (cnt_q == '0);
	assign last_a = AW'(cnt_q - 1'b1);
	assign req_a  = AW'(req.position);
	assign nxt_a  = up_q ? AW'(rda_s1 + 1'b1) : AW'(rda_s1 - 1'b1);
	assign kept_n = (rd_data != data_q) ? CW'(kept_q + 1'b1) : kept_q;

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		done_d  = 1'b0;
		op_d    = op_q;
		pos_d   = pos_q;
		data_d  = data_q;
		end_d   = end_q;
		up_d    = up_q;
		kept_d  = kept_q;
		val_d   = val_q;
		rsp_d   = rsp_q;
		rda_d   = rda_s1;
		last_d  = last_s1;
		ram_we  = 1'b0;
		ram_wa  = '0;
		ram_wd  = '0;
		ram_re  = 1'b0;
		ram_ra  = '0;

		case (state_q)
			S_IDLE: begin
				if (acc) begin
					op_d   = req.op;
					pos_d  = req_a;
					data_d = req.data;
					// rejected items and items that need no walk answer at once
					done_d = 1'b1;
					rsp_d  = '{status: STAT_RANGE, read_value: '0,
						count: POS_W'(cnt_q)};
					case (req.op)
						OP_PUSH: begin
							if (full) begin
								rsp_d.status = STAT_FULL;
							end else begin
								ram_we       = 1'b1;
								ram_wa       = AW'(cnt_q);
								ram_wd       = req.data;
								cnt_d        = CW'(cnt_q + 1'b1);
								rsp_d.status = STAT_OK;
								rsp_d.count  = POS_W'(CW'(cnt_q + 1'b1));
							end
						end
						OP_POP: begin
							if (!empty) begin
								ram_re  = 1'b1;
								ram_ra  = last_a;
								rda_d   = last_a;
								last_d  = 1'b1;
								cnt_d   = CW'(cnt_q - 1'b1);
								done_d  = 1'b0;
								state_d = S_SCAN;
							end
						end
						OP_READ: begin
							if (pos_x < cnt_x) begin
								ram_re  = 1'b1;
								ram_ra  = req_a;
								rda_d   = req_a;
								last_d  = 1'b1;
								done_d  = 1'b0;
								state_d = S_SCAN;
							end
						end
						OP_INSERT: begin
							// index is checked before fullness
							if (pos_x > cnt_x) begin
								rsp_d.status = STAT_RANGE;
							end else if (full) begin
								rsp_d.status = STAT_FULL;
							end else if (pos_x == cnt_x) begin
								// append, nothing to move
								ram_we       = 1'b1;
								ram_wa       = req_a;
								ram_wd       = req.data;
								cnt_d        = CW'(cnt_q + 1'b1);
								rsp_d.status = STAT_OK;
								rsp_d.count  = POS_W'(CW'(cnt_q + 1'b1));
							end else begin
								// walk down from the top entry, each moves up one
								ram_re  = 1'b1;
								ram_ra  = last_a;
								rda_d   = last_a;
								last_d  = (last_a == req_a);
								end_d   = req_a;
								up_d    = 1'b0;
								cnt_d   = CW'(cnt_q + 1'b1);
								done_d  = 1'b0;
								state_d = S_SCAN;
							end
						end
						OP_DELETE: begin
							if (pos_x < cnt_x) begin
								// walk up from the deleted entry, each moves down one
								ram_re  = 1'b1;
								ram_ra  = req_a;
								rda_d   = req_a;
								last_d  = (req_a == last_a);
								end_d   = last_a;
								up_d    = 1'b1;
								cnt_d   = CW'(cnt_q - 1'b1);
								done_d  = 1'b0;
								state_d = S_SCAN;
							end
						end
						OP_REMOVE: begin
							if (!empty) begin
								// compacting walk over the whole table
								ram_re  = 1'b1;
								ram_ra  = '0;
								rda_d   = '0;
								last_d  = (last_a == '0);
								end_d   = last_a;
								up_d    = 1'b1;
								kept_d  = '0;
								done_d  = 1'b0;
								state_d = S_SCAN;
							end
						end
						default: begin
							rsp_d.status = STAT_RANGE;
						end
					endcase
				end
			end

			S_SCAN: begin
				// keep one read in flight until the final address
				if (!last_s1) begin
					ram_re = 1'b1;
					ram_ra = nxt_a;
					rda_d  = nxt_a;
					last_d = (nxt_a == end_q);
				end
				// reads run ahead of writes in the walk direction, so the same
				// entry is never read and written in one cycle
				case (op_q)
					OP_INSERT: begin
						ram_we = 1'b1;
						ram_wa = AW'(rda_s1 + 1'b1);
						ram_wd = rd_data;
						if (last_s1) begin
							state_d = S_INSFIN;
						end
					end
					OP_DELETE: begin
						if (rda_s1 == pos_q) begin
							val_d = rd_data;
						end else begin
							ram_we = 1'b1;
							ram_wa = AW'(rda_s1 - 1'b1);
							ram_wd = rd_data;
						end
						if (last_s1) begin
							done_d  = 1'b1;
							rsp_d   = '{status: STAT_OK,
								read_value: (rda_s1 == pos_q) ? rd_data : val_q,
								count: POS_W'(cnt_q)};
							state_d = S_IDLE;
						end
					end
					OP_REMOVE: begin
						if (rd_data != data_q) begin
							ram_we = 1'b1;
							ram_wa = AW'(kept_q);
							ram_wd = rd_data;
						end
						kept_d = kept_n;
						if (last_s1) begin
							cnt_d   = kept_n;
							done_d  = 1'b1;
							rsp_d   = '{status: STAT_OK, read_value: '0,
								count: POS_W'(kept_n)};
							state_d = S_IDLE;
						end
					end
					default: begin
						// pop and read: the word just fetched
						done_d  = 1'b1;
						rsp_d   = '{status: STAT_OK, read_value: rd_data,
							count: POS_W'(cnt_q)};
						state_d = S_IDLE;
					end
				endcase
			end

			S_INSFIN: begin
				// the gap is open, drop the new word in
				ram_we  = 1'b1;
				ram_wa  = pos_q;
				ram_wd  = data_q;
				done_d  = 1'b1;
				rsp_d   = '{status: STAT_OK, read_value: '0, count: POS_W'(cnt_q)};
				state_d = S_IDLE;
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		op_q    <= op_d;
		pos_q   <= pos_d;
		data_q  <= data_d;
		end_q   <= end_d;
		up_q    <= up_d;
		kept_q  <= kept_d;
		val_q   <= val_d;
		rsp_q   <= rsp_d;
		rda_s1  <= rda_d;
		last_s1 <= last_d;
	end

	sat_ram #(
		.WIDTH(WORD_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_wa),
		.wdata(ram_wd),
		.re   (ram_re),
		.raddr(ram_ra),
		.rdata(rd_data)
	);

	assign done = done_q;
	assign rsp  = rsp_q;

	// a result only follows an accepted item or the end of a walk
	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ($past(start && !busy) || $past(state_q != S_IDLE)))
		else $error("result without a request");

	// the count never passes the table depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("count beyond depth");

	// compaction never writes ahead of the entry being read
	a_kept_behind: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && op_q == OP_REMOVE) |-> (kept_q <= CW'(rda_s1)))
		else $error("remove write overtakes read");

	// a push into a table with room adds exactly one entry
	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req.op == OP_PUSH && cnt_q != CW'(DEPTH))
		|=> (cnt_q == CW'($past(cnt_q) + 1'b1)))
		else $error("push did not grow the table");

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the shifting array table
// ----------------------------------------------------------------------------
// Drives push, pop, insert, delete, read and remove requests through the
// start/busy handshake and tracks a shadow copy of the table. The shadow
// works out each expected response when its item is accepted. Every done
// pulse is checked against the oldest outstanding expectation. Stimulus
// opens with a short directed list of edge cases. Random phases then fill
// the table to full, shrink it to nearly empty and churn it in between.
// ----------------------------------------------------------------------------
module testbench;
	import sat_pkg::*;

	localparam int TABLE_DEPTH = 256;
	localparam int ITEM_TARGET = 1700;
	localparam int LIMIT_CYCLES = 2000000;
	localparam int TAIL_CYCLES = 300;
	localparam int QUIET_FROM = 700;
	localparam int QUIET_TO = 1050;

	// op codes the block does not define, answered with a range status
	localparam logic [OP_W-1:0] OP_UNDEF_LO = 3'd6;
	localparam logic [OP_W-1:0] OP_UNDEF_HI = 3'd7;

	// random stimulus trends: grow to full, shrink to nearly empty, mixed churn
	typedef enum {FILLING, EMPTYING, CHURNING} trend_t;

	// shadow table plus the queue of responses still owed by the block
	class sat_tracker;
		bit signed [WORD_W-1:0] words [TABLE_DEPTH];
		int fill;
		rsp_t awaited [$];
		int errors;
		int op_tally [8];
		int full_hits;
		int peak_fill;

		function new();
			foreach (words[i]) words[i] = '0;
			foreach (op_tally[i]) op_tally[i] = 0;
			fill = 0;
			errors = 0;
			full_hits = 0;
			peak_fill = 0;
		endfunction

		function void complain(string note);
			errors++;
			if (errors <= 10) $display("%0t mismatch: %s", $realtime, note);
		endfunction

		// apply one accepted item to the shadow and queue its response
		function void take_request(req_t item);
			rsp_t outcome;
			int n;
			int at;
			int i;
			int kept;
			n = fill;
			at = item.position;
			outcome.status = STAT_OK;
			outcome.read_value = '0;
			op_tally[item.op]++;
			case (item.op)
				OP_PUSH: begin
					if (n >= TABLE_DEPTH) begin
						outcome.status = STAT_FULL;
					end else begin
						words[n] = item.data;
						n++;
					end
				end
				OP_POP: begin
					if (n == 0) begin
						outcome.status = STAT_RANGE;
					end else begin
						n--;
						outcome.read_value = words[n];
					end
				end
				OP_INSERT: begin
					// index is judged before fullness
					if (at > n) begin
						outcome.status = STAT_RANGE;
					end else if (n >= TABLE_DEPTH) begin
						outcome.status = STAT_FULL;
					end else begin
						for (i = n; i > at; i--) words[i] = words[i-1];
						words[at] = item.data;
						n++;
					end
				end
				OP_DELETE: begin
					if (at >= n) begin
						outcome.status = STAT_RANGE;
					end else begin
						outcome.read_value = words[at];
						for (i = at; i + 1 < n; i++) words[i] = words[i+1];
						n--;
					end
				end
				OP_READ: begin
					if (at >= n) outcome.status = STAT_RANGE;
					else outcome.read_value = words[at];
				end
				OP_REMOVE: begin
					if (n == 0) begin
						outcome.status = STAT_RANGE;
					end else begin
						kept = 0;
						for (i = 0; i < n; i++) begin
							if (words[i] != item.data) begin
								words[kept] = words[i];
								kept++;
							end
						end
						n = kept;
					end
				end
				default: outcome.status = STAT_RANGE;
			endcase
			if (outcome.status == STAT_FULL) full_hits++;
			fill = n;
			if (fill > peak_fill) peak_fill = fill;
			outcome.count = POS_W'(fill);
			awaited.push_back(outcome);
		endfunction

		// compare one response from the block with the oldest expectation
		function void match_response(rsp_t got);
			rsp_t want;
			if (awaited.size() == 0) begin
				complain($sformatf(
					"response with none outstanding: status %0d value %0d count %0d",
					got.status, got.read_value, got.count));
				return;
			end
			want = awaited.pop_front();
			if (got.status !== want.status || got.read_value !== want.read_value ||
					got.count !== want.count)
				complain($sformatf(
					{"expected status %0d value %0d count %0d, ",
					"got status %0d value %0d count %0d"},
					want.status, want.read_value, want.count,
					got.status, got.read_value, got.count));
		endfunction

		function void settle();
			if (awaited.size() != 0)
				complain($sformatf("%0d responses never arrived", awaited.size()));
		endfunction

		function logic signed [WORD_W-1:0] word_at(int k);
			return words[k];
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	req_t req = '0;
	logic busy;
	logic done;
	rsp_t rsp;

	sat_tracker sb;
	int items_sent = 0;
	int cycle_ctr = 0;

	shifting_array_table #(
		.DEPTH(TABLE_DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.req(req),
		.busy(busy),
		.done(done),
		.rsp(rsp)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// response side: the block cannot be stalled, so every done pulse is taken
	always @(posedge clk) begin
		if (arst_n && done) sb.match_response(rsp);
	end

	// watchdog on the whole run
	initial begin
		while (cycle_ctr < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_ctr++;
		end
		$display("testbench: errors");
		$finish;
	end

	function automatic req_t make_req(logic [OP_W-1:0] op, int at,
			logic signed [WORD_W-1:0] word);
		req_t item;
		item.op = op;
		item.position = POS_W'(at);
		item.data = word;
		return item;
	endfunction

	// word values lean on a small pool so that remove finds duplicates
	function automatic logic signed [WORD_W-1:0] pick_word();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll < 4) return $signed(WORD_W'($urandom_range(0, 7))) - 32'sd3;
		if (roll == 4) begin
			case ($urandom_range(0, 3))
				0: return 32'sh7fffffff;
				1: return 32'sh80000000;
				2: return 32'sd0;
				default: return -32'sd1;
			endcase
		end
		return $signed($urandom);
	endfunction

	// remove mostly targets a word that is really held
	function automatic logic signed [WORD_W-1:0] pick_target();
		if (sb.fill > 0 && $urandom_range(0, 99) < 60)
			return sb.word_at($urandom_range(0, sb.fill - 1));
		return pick_word();
	endfunction

	// mostly legal indexes, with the count boundary and wild values mixed in
	function automatic logic [POS_W-1:0] pick_position(logic [OP_W-1:0] op);
		int roll;
		int top;
		roll = $urandom_range(0, 99);
		top = (op == OP_INSERT) ? sb.fill : sb.fill - 1;
		if (roll < 72 && top >= 0) return POS_W'($urandom_range(0, top));
		if (roll < 82) return POS_W'(sb.fill);
		if (roll < 88) return POS_W'((sb.fill > 0) ? sb.fill - 1 : 0);
		if (roll < 92) return '0;
		if (roll < 98) return POS_W'($urandom_range(0, 511));
		return '1;
	endfunction

	function automatic logic [OP_W-1:0] pick_op(trend_t trend);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll >= 96)
			return ($urandom_range(0, 1) != 0) ? OP_UNDEF_HI : OP_UNDEF_LO;
		case (trend)
			FILLING: begin
				if (roll < 45) return OP_PUSH;
				if (roll < 80) return OP_INSERT;
				if (roll < 86) return OP_READ;
				if (roll < 90) return OP_DELETE;
				if (roll < 93) return OP_POP;
				return OP_REMOVE;
			end
			EMPTYING: begin
				if (roll < 25) return OP_POP;
				if (roll < 60) return OP_DELETE;
				if (roll < 74) return OP_REMOVE;
				if (roll < 84) return OP_READ;
				if (roll < 90) return OP_PUSH;
				return OP_INSERT;
			end
			default: begin
				if (roll < 20) return OP_PUSH;
				if (roll < 40) return OP_INSERT;
				if (roll < 50) return OP_POP;
				if (roll < 65) return OP_DELETE;
				if (roll < 85) return OP_READ;
				return OP_REMOVE;
			end
		endcase
	endfunction

	// hold the item until the block takes it, then book it in the shadow
	task automatic put_item(req_t item);
		start <= 1'b1;
		req <= item;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.take_request(item);
	endtask

	// sender gap with junk on the request bus
	task automatic idle(int span);
		req_t junk;
		junk.op = OP_W'($urandom);
		junk.position = POS_W'($urandom);
		junk.data = $signed($urandom);
		start <= 1'b0;
		req <= junk;
		repeat (span) @(posedge clk);
	endtask

	task automatic send(req_t item);
		bit quiet;
		put_item(item);
		items_sent++;
		quiet = (items_sent >= QUIET_FROM && items_sent < QUIET_TO);
		if (!quiet && $urandom_range(0, 99) < 31)
			idle(($urandom_range(0, 9) == 0) ?
				$urandom_range(5, 30) : $urandom_range(1, 3));
	endtask

	// hold off until every outstanding response is back
	task automatic pause_until_drained();
		start <= 1'b0;
		do @(posedge clk); while (sb.awaited.size() != 0);
	endtask

	initial begin
		trend_t trend;
		int full_stay;
		int churn_left;
		req_t item;
		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table: everything but an append at index zero is refused
		send(make_req(OP_POP, 0, 32'sd0));
		send(make_req(OP_REMOVE, 0, 32'sd0));
		send(make_req(OP_READ, 0, 32'sd0));
		send(make_req(OP_DELETE, 0, 32'sd0));
		send(make_req(OP_INSERT, 1, 32'sd9));
		send(make_req(OP_INSERT, 0, 32'sh7fffffff));
		// extreme words, then an insert into the middle and one at the count
		send(make_req(OP_PUSH, 0, 32'sh80000000));
		send(make_req(OP_PUSH, 511, -32'sd1));
		send(make_req(OP_PUSH, 0, 32'sd0));
		send(make_req(OP_INSERT, 1, 32'sd5));
		send(make_req(OP_INSERT, 5, -32'sd1));
		// reads either side of the count and with every index bit set
		send(make_req(OP_READ, 0, 32'sd0));
		send(make_req(OP_READ, 5, 32'sd0));
		send(make_req(OP_READ, 6, 32'sd0));
		send(make_req(OP_READ, 511, 32'sd0));
		// deletes at the front, the back and past the end
		send(make_req(OP_DELETE, 0, 32'sd0));
		send(make_req(OP_DELETE, 4, 32'sd0));
		send(make_req(OP_DELETE, 4, 32'sd0));
		// remove with and without a match
		send(make_req(OP_PUSH, 0, 32'sd5));
		send(make_req(OP_REMOVE, 0, 32'sd5));
		send(make_req(OP_REMOVE, 0, 32'sd12345));
		// undefined ops and an index with only the top bit set
		send(make_req(OP_UNDEF_LO, 0, 32'sd0));
		send(make_req(OP_UNDEF_HI, 511, -32'sd1));
		send(make_req(OP_INSERT, 256, 32'sd0));
		send(make_req(OP_POP, 0, 32'sd0));
		pause_until_drained();

		// random phases: grow to full and linger, shrink, then churn
		trend = FILLING;
		full_stay = 0;
		churn_left = 0;
		while (items_sent < ITEM_TARGET) begin
			item.op = pick_op(trend);
			item.position = pick_position(item.op);
			item.data = (item.op == OP_REMOVE) ? pick_target() : pick_word();
			send(item);
			case (trend)
				FILLING: begin
					if (sb.fill >= TABLE_DEPTH) full_stay++;
					if (full_stay >= 40) begin
						trend = EMPTYING;
						full_stay = 0;
						pause_until_drained();
					end
				end
				EMPTYING: begin
					if (sb.fill <= 3) begin
						trend = CHURNING;
						churn_left = 150;
					end
				end
				default: begin
					churn_left--;
					if (churn_left <= 0) trend = FILLING;
				end
			endcase
		end

		pause_until_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		sb.settle();

		$display({"covered %0d items: push %0d pop %0d insert %0d delete %0d ",
			"read %0d remove %0d undefined %0d"},
			items_sent, sb.op_tally[OP_PUSH], sb.op_tally[OP_POP], sb.op_tally[OP_INSERT],
			sb.op_tally[OP_DELETE], sb.op_tally[OP_READ], sb.op_tally[OP_REMOVE],
			sb.op_tally[OP_UNDEF_LO] + sb.op_tally[OP_UNDEF_HI]);
		$display("full table refusals %0d, peak count %0d, mismatches %0d",
			sb.full_hits, sb.peak_fill, sb.errors);
		if (sb.errors == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule

### files.f
src/sat_pkg.sv
src/sat_ram.sv
src/shifting_array_table.sv
tb/testbench.sv
